[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line and column tracker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TLCT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TLCT_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

[rtl/tlct_pkg.sv]
// ---------------------------------------------------------------------------
// tlct_pkg
// Types, codes and constants shared by the line and column tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlct_pkg;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 104;
  localparam int COUNT_W   = 22;

  localparam logic [15:0] COL_MAX      = 16'hFFFF;
  localparam logic [7:0]  NEWLINE_CHAR = 8'd10;

  typedef enum logic {
    CMD_ADVANCE = 1'b0,
    CMD_RETREAT = 1'b1
  } cmd_t;

  typedef enum logic {
    KIND_TOKEN   = 1'b0,
    KIND_RETREAT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_CHECK,
    ST_WALK,
    ST_LOAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] begin_line;
    logic [15:0] begin_column;
    logic [31:0] end_line;
    logic [15:0] end_column;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

[rtl/text_line_column_tracker_core.sv]
// An advance word is taken while the core is idle and the output register is free; its
// token word is registered and offered on the next cycle, so one character per cycle is
// sustained while the sink keeps up. A retreat word scans the line lengths through the
// memory read port (SCAN, SCAN_LAST, CHECK), then, unless the count exceeds the total,
// walks (WALK trims the top line, WALK and LOAD pop a line); DONE hands off its status.
// Reset is synchronous and immediate: the top line is a register, so no clearing pass.
// ---------------------------------------------------------------------------
// text_line_column_tracker_core
// Tracks token line and column positions with a ring of line lengths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module text_line_column_tracker_core #(
  parameter int HISTORY_LINES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] char_byte, [29:8] retreat_count, [31:30] zero
  input  wire logic [tlct_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] command, [1] first_of_token
  input  wire logic [1:0]  s_tuser,
  // last_of_token
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] begin_line, [47:32] begin_column, [79:48] end_line,
  // [95:80] end_column, [97:96] status, [103:98] zero
  output logic [tlct_pkg::M_TDATA_W-1:0] m_tdata,
  // result_kind
  output logic             m_tuser
);

  localparam int IDX_W   = $clog2(HISTORY_LINES);
  localparam int DEPTH_W = $clog2(HISTORY_LINES + 1);
  localparam int TOTAL_W = $clog2((HISTORY_LINES + 1) * 65535 + 1);
  localparam int CMP_W   = (TOTAL_W > tlct_pkg::COUNT_W) ? TOTAL_W : tlct_pkg::COUNT_W;
  localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(HISTORY_LINES - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(HISTORY_LINES);
  localparam logic [IDX_W:0]     IDX_SPAN   = (IDX_W + 1)'(HISTORY_LINES);

  tlct_pkg::state_t state, state_next;

  logic [15:0]        top_len, top_len_next;
  logic [31:0]        top_line, top_line_next;
  logic [IDX_W-1:0]   top_idx, top_idx_next;
  logic [IDX_W-1:0]   bottom_idx, bottom_idx_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic [31:0]        tb_line, tb_line_next;
  logic [15:0]        tb_col, tb_col_next;
  logic [tlct_pkg::COUNT_W-1:0] count, count_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic [IDX_W-1:0]   scan_addr, scan_addr_next;
  logic [DEPTH_W-1:0] scan_i, scan_i_next;
  logic               pend, pend_top;
  tlct_pkg::status_t  status, status_next;

  logic               accept, adv, ret, first, is_nl;
  logic [15:0]        cur_inc, take, rdata;
  logic [IDX_W-1:0]   top_inc, top_dec, bottom_inc, scan_inc;
  logic               count_zero, top_zero, depth_zero, full, range_err, pop;
  logic               out_free, out_load;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_raddr;
  logic [15:0]        mem_wdata;
  tlct_pkg::result_t  out_data;
  logic [31:0]        tok_bline;
  logic [15:0]        tok_bcol, tok_ecol;
  logic [IDX_W:0]     idx_sum, idx_top_ext;
  logic               ring_ok, code_ok;

  assign accept = s_tvalid && s_tready;
  assign adv    = accept && (s_tuser[0] == tlct_pkg::CMD_ADVANCE);
  assign ret    = accept && (s_tuser[0] == tlct_pkg::CMD_RETREAT);
  assign first  = s_tuser[1];
  assign is_nl  = s_tdata[7:0] == tlct_pkg::NEWLINE_CHAR;

  assign cur_inc    = (top_len == tlct_pkg::COL_MAX) ? top_len : top_len + 16'd1;
  assign top_inc    = (top_idx == IDX_LAST) ? '0 : top_idx + 1'b1;
  assign top_dec    = (top_idx == '0) ? IDX_LAST : top_idx - 1'b1;
  assign bottom_inc = (bottom_idx == IDX_LAST) ? '0 : bottom_idx + 1'b1;
  assign scan_inc   = (scan_addr == IDX_LAST) ? '0 : scan_addr + 1'b1;

  assign count_zero = count == '0;
  assign top_zero   = top_len == 16'd0;
  assign depth_zero = depth == '0;
  assign full       = depth == DEPTH_FULL;
  assign range_err  = CMP_W'(count) > CMP_W'(total);
  assign take       = (tlct_pkg::COUNT_W'(top_len) > count) ? count[15:0] : top_len;
  assign pop        = (state == tlct_pkg::ST_WALK) && !count_zero && top_zero && !depth_zero;

  // Token location: a trailing newline reports the end on the line it closed.
  always_comb begin
    tok_bline = first ? top_line : tb_line;
    tok_bcol  = first ? cur_inc : tb_col;
    tok_ecol  = cur_inc;
    if (is_nl) begin
      tok_ecol = cur_inc - 16'd1;
      if (cur_inc == tok_bcol) begin
        tok_bcol = tok_ecol;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlct_pkg::ST_IDLE: begin
        if (ret) begin
          state_next = tlct_pkg::ST_SCAN;
        end
      end
      tlct_pkg::ST_SCAN: begin
        if (scan_i == depth) begin
          state_next = tlct_pkg::ST_SCAN_LAST;
        end
      end
      tlct_pkg::ST_SCAN_LAST: begin
        state_next = tlct_pkg::ST_CHECK;
      end
      tlct_pkg::ST_CHECK: begin
        state_next = range_err ? tlct_pkg::ST_DONE : tlct_pkg::ST_WALK;
      end
      tlct_pkg::ST_WALK: begin
        priority if (count_zero) begin
          state_next = tlct_pkg::ST_DONE;
        end else if (top_zero && depth_zero) begin
          state_next = tlct_pkg::ST_DONE;
        end else if (top_zero) begin
          state_next = tlct_pkg::ST_LOAD;
        end
      end
      tlct_pkg::ST_LOAD: begin
        state_next = (rdata == 16'd0) ? tlct_pkg::ST_DONE : tlct_pkg::ST_WALK;
      end
      tlct_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tlct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tlct_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = (state == tlct_pkg::ST_IDLE) && out_free;
    mem_raddr = (state == tlct_pkg::ST_WALK) ? top_dec : scan_addr;
    mem_we    = (adv && is_nl) || pop;
    mem_wdata = adv ? cur_inc : top_len;
    out_load  = (adv && s_tlast) || ((state == tlct_pkg::ST_DONE) && out_free);
    if (state == tlct_pkg::ST_DONE) begin
      out_data = '{kind: tlct_pkg::KIND_RETREAT, begin_line: 32'd0, begin_column: 16'd0,
                   end_line: 32'd0, end_column: 16'd0, status: status};
    end else begin
      out_data = '{kind: tlct_pkg::KIND_TOKEN, begin_line: tok_bline,
                   begin_column: tok_bcol, end_line: top_line, end_column: tok_ecol,
                   status: tlct_pkg::STATUS_OK};
    end
  end

  always_comb begin
    top_len_next    = top_len;
    top_line_next   = top_line;
    top_idx_next    = top_idx;
    bottom_idx_next = bottom_idx;
    depth_next      = depth;
    tb_line_next    = tb_line;
    tb_col_next     = tb_col;
    count_next      = count;
    total_next      = total;
    scan_addr_next  = scan_addr;
    scan_i_next     = scan_i;
    status_next     = status;

    if (pend) begin
      total_next = total + TOTAL_W'(pend_top ? top_len : rdata);
    end

    unique case (state)
      tlct_pkg::ST_IDLE: begin
        if (adv) begin
          if (first) begin
            tb_line_next = top_line;
            tb_col_next  = cur_inc;
          end
          if (is_nl) begin
            top_len_next  = 16'd0;
            top_idx_next  = top_inc;
            top_line_next = top_line + 32'd1;
            if (full) begin
              bottom_idx_next = bottom_inc;
            end else begin
              depth_next = depth + 1'b1;
            end
          end else begin
            top_len_next = cur_inc;
          end
        end
        if (ret) begin
          count_next     = s_tdata[29:8];
          scan_addr_next = bottom_idx;
          scan_i_next    = '0;
          total_next     = '0;
          status_next    = tlct_pkg::STATUS_OK;
        end
      end
      tlct_pkg::ST_SCAN: begin
        scan_addr_next = scan_inc;
        scan_i_next    = scan_i + 1'b1;
      end
      tlct_pkg::ST_SCAN_LAST: begin
      end
      tlct_pkg::ST_CHECK: begin
        if (range_err) begin
          status_next = tlct_pkg::STATUS_RANGE;
        end
      end
      tlct_pkg::ST_WALK: begin
        priority if (count_zero) begin
        end else if (!top_zero) begin
          top_len_next = top_len - take;
          count_next   = count - tlct_pkg::COUNT_W'(take);
        end else if (depth_zero) begin
          status_next = tlct_pkg::STATUS_EXHAUSTED;
        end else begin
          depth_next    = depth - 1'b1;
          top_idx_next  = top_dec;
          top_line_next = top_line - 32'd1;
        end
      end
      tlct_pkg::ST_LOAD: begin
        top_len_next = rdata;
        if (rdata == 16'd0) begin
          status_next = tlct_pkg::STATUS_EXHAUSTED;
        end
      end
      tlct_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tlct_pkg::ST_IDLE;
      top_len    <= 16'd0;
      top_line   <= 32'd1;
      top_idx    <= '0;
      bottom_idx <= '0;
      depth      <= '0;
      tb_line    <= 32'd0;
      tb_col     <= 16'd0;
      pend       <= 1'b0;
    end else begin
      state      <= state_next;
      top_len    <= top_len_next;
      top_line   <= top_line_next;
      top_idx    <= top_idx_next;
      bottom_idx <= bottom_idx_next;
      depth      <= depth_next;
      tb_line    <= tb_line_next;
      tb_col     <= tb_col_next;
      pend       <= state == tlct_pkg::ST_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    count     <= count_next;
    total     <= total_next;
    scan_addr <= scan_addr_next;
    scan_i    <= scan_i_next;
    status    <= status_next;
    pend_top  <= scan_addr == top_idx;
  end

  tlct_line_mem #(
    .DEPTH (HISTORY_LINES),
    .WIDTH (16)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (top_idx),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  tlct_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .data     (out_data),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  assign idx_sum     = (IDX_W + 1)'(bottom_idx) + (IDX_W + 1)'(depth);
  assign idx_top_ext = (IDX_W + 1)'(top_idx);
  assign ring_ok     = (idx_top_ext == idx_sum) || (idx_top_ext + IDX_SPAN == idx_sum);
  assign code_ok     = (m_tdata[97:96] == tlct_pkg::STATUS_OK) ||
                       (m_tdata[97:96] == tlct_pkg::STATUS_RANGE) ||
                       (m_tdata[97:96] == tlct_pkg::STATUS_EXHAUSTED);

  `TLCT_ASSERT_IMP(a_ring_span, clk, rst, 1'b1, ring_ok)
  `TLCT_ASSERT_IMP(a_depth_bound, clk, rst, 1'b1, depth <= DEPTH_FULL)
  `TLCT_ASSERT_NXT(a_retreat_scans, clk, rst, ret, state == tlct_pkg::ST_SCAN)
  `TLCT_ASSERT_IMP(a_status_code, clk, rst, m_tvalid, code_ok)

endmodule

`default_nettype wire

[rtl/tlct_line_mem.sv]
// ---------------------------------------------------------------------------
// tlct_line_mem
// Line length store: one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlct_line_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/tlct_out_reg.sv]
// ---------------------------------------------------------------------------
// tlct_out_reg
// Output register for result words, decoupling the core from the sink.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlct_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire tlct_pkg::result_t    data,
  output logic                      free,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [tlct_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                      m_tuser
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'd0, data.status, data.end_column, data.end_line,
                  data.begin_column, data.begin_line};
      m_tuser <= data.kind;
    end
  end

endmodule

`default_nettype wire
